### hdl/qsw_pkg.sv
// ----------------------------------------------------------------------------
// qsw_pkg
// Shared widths, field layout and register codes of the quantizing
// sliding-window unit.
// ----------------------------------------------------------------------------
package qsw_pkg;

  localparam int SAMPLE_W   = 16;  // input sample, signed, 8 fraction bits
  localparam int INV_W      = 24;  // inverse scale, unsigned Q8.16
  localparam int ZP_W       = 8;   // zero point, signed
  localparam int COL_W      = 8;   // quantized value, signed
  localparam int TIDX_W     = 6;   // time index field
  localparam int CH_CNT_W   = 3;   // channels_in_use register
  localparam int WL_W       = 7;   // window_length register
  localparam int HOP_W      = 8;   // hop_length register and since counter
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // product of a signed sample by the zero-extended inverse scale
  localparam int PROD_W     = SAMPLE_W + INV_W + 1;
  // product carries 24 fraction bits
  localparam int RND_SHIFT  = 24;
  localparam int QMAG_W     = PROD_W - RND_SHIFT;
  localparam int QSUM_W     = QMAG_W + 2;

  localparam logic signed [QSUM_W-1:0] Q_MIN = -QSUM_W'(128);
  localparam logic signed [QSUM_W-1:0] Q_MAX = QSUM_W'(127);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNELS   = 3'd0,
    CFG_WINDOW_LEN = 3'd1,
    CFG_HOP_LEN    = 3'd2,
    CFG_INV_SCALE  = 3'd3,
    CFG_ZERO_POINT = 3'd4
  } cfg_idx_e;

  localparam logic [CH_CNT_W-1:0] CHANNELS_RST  = 3'd6;
  localparam logic [WL_W-1:0]     WINDOW_RST    = 7'd64;
  localparam logic [HOP_W-1:0]    HOP_RST       = 8'd0;
  localparam logic [INV_W-1:0]    INV_SCALE_RST = 24'd65536;
  localparam logic [ZP_W-1:0]     ZERO_PT_RST   = 8'd0;

  localparam logic [HOP_W-1:0]    SINCE_MAX     = 8'd255;

endpackage

### hdl/qsw_ram.sv
// ----------------------------------------------------------------------------
// qsw_ram
// Generic single-write, single-read RAM with registered read data and
// read enable.
// ----------------------------------------------------------------------------
module qsw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/qsw_lane.sv
// ----------------------------------------------------------------------------
// qsw_lane
// One channel quantizer: registered multiply by the inverse scale, then
// round half away from zero, add zero point and saturate to int8.
// ----------------------------------------------------------------------------
module qsw_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [qsw_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic        [qsw_pkg::INV_W-1:0]     inv_scale_i,
  input  logic signed [qsw_pkg::ZP_W-1:0]      zero_point_i,
  output logic signed [qsw_pkg::COL_W-1:0]     quant_o
);

  localparam int PW = qsw_pkg::PROD_W;
  localparam int QW = qsw_pkg::QSUM_W;

  logic signed [PW-1:0]                 prod_q;
  logic                                 neg;
  logic        [PW-1:0]                 mag;
  logic        [PW-1:0]                 rnd;
  logic        [qsw_pkg::QMAG_W-1:0]    qmag;
  logic signed [QW-1:0]                 qsgn;
  logic signed [QW-1:0]                 qsum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(sample_i * $signed({1'b0, inv_scale_i}));
    end
  end

  always_comb begin
    neg  = prod_q[PW-1];
    mag  = neg ? PW'(-prod_q) : PW'(prod_q);
    rnd  = mag + (PW'(1) << (qsw_pkg::RND_SHIFT - 1));
    qmag = rnd[PW-1:qsw_pkg::RND_SHIFT];
    qsgn = neg ? -$signed(QW'(qmag)) : $signed(QW'(qmag));
    qsum = qsgn + QW'(zero_point_i);
    if (qsum < qsw_pkg::Q_MIN) begin
      quant_o = qsw_pkg::COL_W'(qsw_pkg::Q_MIN);
    end else if (qsum > qsw_pkg::Q_MAX) begin
      quant_o = qsw_pkg::COL_W'(qsw_pkg::Q_MAX);
    end else begin
      quant_o = qsw_pkg::COL_W'(qsum);
    end
  end

endmodule

### hdl/quantized_sliding_window_unit.sv
// ----------------------------------------------------------------------------
// quantized_sliding_window_unit
// Quantizes every channel of a sample to int8 in parallel lanes, stores the
// column in a ring and emits the whole window, oldest column first, once the
// ring is full and the hop has elapsed.
// ----------------------------------------------------------------------------
// Flow: an accepted item is quantized into the lane registers and written
//   to the ring in the QNT state; an emitting item then reads the window in
//   the EMIT state, one column per cycle while the output does not stall. A
//   new item is accepted only in the IDLE state.
// Reset: control state, counters and registers return to their defaults;
//   ring contents are not cleared, and no clearing pass is run.
// ----------------------------------------------------------------------------
module quantized_sliding_window_unit #(
  parameter int MAX_CHANNELS = 6,
  parameter int MAX_WINDOW   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample_ch0 .. sample_ch(MAX_CHANNELS-1), 16 bits each, from bit 0 up
  input  logic [MAX_CHANNELS*qsw_pkg::SAMPLE_W-1:0] s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // column_ch0 .. column_ch(MAX_CHANNELS-1), 8 bits each, then time_index,
  // then zero fill, from bit 0 up
  output logic [((MAX_CHANNELS*qsw_pkg::COL_W+qsw_pkg::TIDX_W+7)/8)*8-1:0]
                                            m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qsw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qsw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int LW     = $clog2(MAX_WINDOW + 1);
  localparam int ROW_W  = MAX_CHANNELS * qsw_pkg::COL_W;
  localparam int OUT_W  = ((ROW_W + qsw_pkg::TIDX_W + 7) / 8) * 8;
  localparam int PAD_W  = OUT_W - ROW_W - qsw_pkg::TIDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QNT,
    ST_EMIT
  } state_e;

  state_e                          state_q, state_d;
  logic [qsw_pkg::CH_CNT_W-1:0]    chan_q, chan_d;
  logic [qsw_pkg::WL_W-1:0]        wlen_q, wlen_d;
  logic [qsw_pkg::HOP_W-1:0]       hop_q, hop_d;
  logic [qsw_pkg::INV_W-1:0]       inv_q, inv_d;
  logic [qsw_pkg::ZP_W-1:0]        zp_q, zp_d;
  logic [AW-1:0]                   head_q, head_d;
  logic [LW-1:0]                   fill_q, fill_d;
  logic [qsw_pkg::HOP_W-1:0]       since_q, since_d;
  logic [LW-1:0]                   rd_cnt_q, rd_cnt_d;
  logic                            m_valid_q, m_valid_d;
  logic [AW-1:0]                   tidx_q, tidx_d;
  logic                            last_q, last_d;

  logic [LW-1:0]                   len;
  logic [qsw_pkg::HOP_W-1:0]       hop_eff;
  logic [LW-1:0]                   fill_nxt;
  logic [qsw_pkg::HOP_W-1:0]       since_nxt;
  logic [LW-1:0]                   head_inc;
  logic [LW:0]                     rd_sum;
  logic [AW-1:0]                   rd_addr;
  logic                            accept;
  logic                            cfg_we;
  logic                            load;
  logic                            ram_we;
  logic [ROW_W-1:0]                row_wdata;
  logic [ROW_W-1:0]                row_rdata;
  logic [ROW_W-1:0]                row_masked;
  logic signed [qsw_pkg::COL_W-1:0] lane_q [MAX_CHANNELS];

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign cfg_we          = cfg_valid_i && cfg_ready_o;

  // Quantizer lanes, one per channel
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    qsw_lane u_lane (
      .clk_i        (clk_i),
      .en_i         (accept),
      .sample_i     (s_axis_tdata_i[c*qsw_pkg::SAMPLE_W +: qsw_pkg::SAMPLE_W]),
      .inv_scale_i  (inv_q),
      .zero_point_i (zp_q),
      .quant_o      (lane_q[c])
    );
  end

  // Merge lanes into one column; inactive channels hold 0
  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (4'(c) < {1'b0, chan_q}) begin
        row_wdata[c*qsw_pkg::COL_W +: qsw_pkg::COL_W]  = lane_q[c];
        row_masked[c*qsw_pkg::COL_W +: qsw_pkg::COL_W] =
          row_rdata[c*qsw_pkg::COL_W +: qsw_pkg::COL_W];
      end else begin
        row_wdata[c*qsw_pkg::COL_W +: qsw_pkg::COL_W]  = '0;
        row_masked[c*qsw_pkg::COL_W +: qsw_pkg::COL_W] = '0;
      end
    end
  end

  assign ram_we = (state_q == ST_QNT);

  qsw_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (row_wdata),
    .re_i    (load),
    .raddr_i (rd_addr),
    .rdata_o (row_rdata)
  );

  // Effective window and hop
  always_comb begin
    if (wlen_q == '0) begin
      len = LW'(1);
    end else if (wlen_q > qsw_pkg::WL_W'(MAX_WINDOW)) begin
      len = LW'(MAX_WINDOW);
    end else begin
      len = LW'(wlen_q);
    end
    hop_eff   = (hop_q == '0) ? qsw_pkg::HOP_W'(len) : hop_q;
    fill_nxt  = (fill_q < len) ? fill_q + 1'b1 : fill_q;
    since_nxt = (since_q < qsw_pkg::SINCE_MAX) ? since_q + 1'b1 : since_q;
    head_inc  = LW'(head_q) + 1'b1;
    // oldest column sits at the write head; wrap once
    rd_sum    = (LW+1)'(head_q) + (LW+1)'(rd_cnt_q);
    if (rd_sum >= (LW+1)'(len)) begin
      rd_sum = rd_sum - (LW+1)'(len);
    end
    rd_addr   = rd_sum[AW-1:0];
    load      = (state_q == ST_EMIT) && (rd_cnt_q < len) &&
                (!m_valid_q || m_axis_tready_i);
  end

  always_comb begin
    state_d   = state_q;
    chan_d    = chan_q;
    wlen_d    = wlen_q;
    hop_d     = hop_q;
    inv_d     = inv_q;
    zp_d      = zp_q;
    head_d    = head_q;
    fill_d    = fill_q;
    since_d   = since_q;
    rd_cnt_d  = rd_cnt_q;
    tidx_d    = tidx_q;
    last_d    = last_q;
    m_valid_d = m_axis_tready_i ? 1'b0 : m_valid_q;

    if (cfg_we) begin
      case (cfg_index_i)
        qsw_pkg::CFG_CHANNELS:   chan_d = cfg_data_i[qsw_pkg::CH_CNT_W-1:0];
        qsw_pkg::CFG_WINDOW_LEN: begin
          wlen_d  = cfg_data_i[qsw_pkg::WL_W-1:0];
          head_d  = '0;
          fill_d  = '0;
          since_d = '0;
        end
        qsw_pkg::CFG_HOP_LEN:    hop_d  = cfg_data_i[qsw_pkg::HOP_W-1:0];
        qsw_pkg::CFG_INV_SCALE:  inv_d  = cfg_data_i[qsw_pkg::INV_W-1:0];
        qsw_pkg::CFG_ZERO_POINT: zp_d   = cfg_data_i[qsw_pkg::ZP_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_QNT;
        end
      end
      ST_QNT: begin
        // column is written this cycle; advance head and counters
        head_d   = (head_inc == len) ? '0 : head_q + 1'b1;
        fill_d   = fill_nxt;
        rd_cnt_d = '0;
        if (fill_nxt >= len && since_nxt >= hop_eff) begin
          since_d = '0;
          state_d = ST_EMIT;
        end else begin
          since_d = since_nxt;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load) begin
          m_valid_d = 1'b1;
          tidx_d    = rd_cnt_q[AW-1:0];
          last_d    = (rd_cnt_q + 1'b1 == len);
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end else if (rd_cnt_q == len) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chan_q    <= qsw_pkg::CHANNELS_RST;
      wlen_q    <= qsw_pkg::WINDOW_RST;
      hop_q     <= qsw_pkg::HOP_RST;
      inv_q     <= qsw_pkg::INV_SCALE_RST;
      zp_q      <= qsw_pkg::ZERO_PT_RST;
      head_q    <= '0;
      fill_q    <= '0;
      since_q   <= '0;
      rd_cnt_q  <= '0;
      m_valid_q <= 1'b0;
      tidx_q    <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      chan_q    <= chan_d;
      wlen_q    <= wlen_d;
      hop_q     <= hop_d;
      inv_q     <= inv_d;
      zp_q      <= zp_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      since_q   <= since_d;
      rd_cnt_q  <= rd_cnt_d;
      m_valid_q <= m_valid_d;
      tidx_q    <= tidx_d;
      last_q    <= last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {PAD_W'(0), qsw_pkg::TIDX_W'(tidx_q), row_masked};

endmodule

### bench/quantized_sliding_window_unit_test.sv
// ----------------------------------------------------------------------------
// quantized_sliding_window_unit_test
// Self-checking bench for the quantizing sliding-window unit. A table of
// directed items covers rounding, saturation, zero point, channel counts and
// window restarts; random phases with varied register settings follow. Every
// accepted sample goes through a local model of the ring, and each column on
// the output stream is compared with the oldest predicted column.
// ----------------------------------------------------------------------------
module quantized_sliding_window_unit_test;

  localparam int SAMPLE_W     = qsw_pkg::SAMPLE_W;
  localparam int COL_W        = qsw_pkg::COL_W;
  localparam int TIDX_W       = qsw_pkg::TIDX_W;
  localparam int CFG_DATA_W   = qsw_pkg::CFG_DATA_W;
  localparam int NCH          = 6;
  localparam int WIN_MAX      = 64;
  localparam int OUT_W        = ((NCH*COL_W+TIDX_W+7)/8)*8;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 450;

  typedef logic [NCH-1:0][SAMPLE_W-1:0] sample_vec_t;
  typedef logic [NCH-1:0][COL_W-1:0]    column_vec_t;

  typedef struct {
    column_vec_t       cols;
    logic [TIDX_W-1:0] tidx;
    logic              last;
  } column_t;

  typedef struct {
    logic                  is_cfg;
    qsw_pkg::cfg_idx_e     idx;
    logic [CFG_DATA_W-1:0] data;
    sample_vec_t           smp;
    logic                  has_exp;
    column_vec_t           exp_cols;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  sample_vec_t           s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_W-1:0]      m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tvalid_o;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  qsw_pkg::cfg_idx_e     cfg_index = qsw_pkg::CFG_CHANNELS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  quantized_sliding_window_unit #(
    .MAX_CHANNELS(NCH),
    .MAX_WINDOW  (WIN_MAX)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the unit: registers, ring and counters
  logic [qsw_pkg::CH_CNT_W-1:0]  reg_channels;
  logic [qsw_pkg::WL_W-1:0]      reg_window;
  logic [qsw_pkg::HOP_W-1:0]     reg_hop;
  logic [qsw_pkg::INV_W-1:0]     reg_inv;
  logic signed [qsw_pkg::ZP_W-1:0] reg_zp;
  column_vec_t             ring_cols [WIN_MAX];
  int                      write_head;
  int                      fill_count;
  int                      since_emit;

  column_t                 expected_columns [$];
  stim_row_t               stim_rows [$];
  int                      errors = 0;
  int                      src_burst = 0;

  function automatic int eff_window();
    if (reg_window == 0) return 1;
    if (reg_window > WIN_MAX) return WIN_MAX;
    return int'(reg_window);
  endfunction

  function automatic logic [COL_W-1:0] quantize_sample(logic signed [SAMPLE_W-1:0] s);
    longint prod;
    longint mag;
    longint q;
    prod = longint'(s) * longint'({1'b0, reg_inv});
    mag  = (prod < 0) ? -prod : prod;
    q    = (mag + (64'sd1 << 23)) >>> 24;
    if (prod < 0) q = -q;
    q = q + longint'(reg_zp);
    if (q < -128) q = -128;
    if (q > 127) q = 127;
    return q[COL_W-1:0];
  endfunction

  task automatic apply_register(qsw_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      qsw_pkg::CFG_CHANNELS:   reg_channels = data[qsw_pkg::CH_CNT_W-1:0];
      qsw_pkg::CFG_WINDOW_LEN: begin
        reg_window = data[qsw_pkg::WL_W-1:0];
        write_head = 0;
        fill_count = 0;
        since_emit = 0;
      end
      qsw_pkg::CFG_HOP_LEN:    reg_hop = data[qsw_pkg::HOP_W-1:0];
      qsw_pkg::CFG_INV_SCALE:  reg_inv = data[qsw_pkg::INV_W-1:0];
      qsw_pkg::CFG_ZERO_POINT: reg_zp = data[qsw_pkg::ZP_W-1:0];
      default: ;
    endcase
  endtask

  // Store one sample and queue the whole window when it is due
  task automatic absorb_sample(sample_vec_t smp);
    int win;
    int hop;
    int head;
    int pos;
    column_t col;
    win  = eff_window();
    hop  = (reg_hop == 0) ? win : int'(reg_hop);
    head = write_head % win;
    for (int c = 0; c < NCH; c++)
      ring_cols[head][c] = (c < reg_channels) ? quantize_sample(smp[c]) : '0;
    write_head = (head + 1) % win;
    if (fill_count < win) fill_count++;
    if (since_emit < qsw_pkg::SINCE_MAX) since_emit++;
    if (fill_count < win || since_emit < hop) return;
    since_emit = 0;
    for (int t = 0; t < win; t++) begin
      pos = (write_head + t) % win;
      for (int c = 0; c < NCH; c++)
        col.cols[c] = (c < reg_channels) ? ring_cols[pos][c] : '0;
      col.tidx = t[TIDX_W-1:0];
      col.last = (t == win - 1);
      expected_columns.push_back(col);
    end
  endtask

  // Long gapless stretches now and then, otherwise a random idle gap
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(5, 40);
    return $urandom_range(0, 14);
  endfunction

  task automatic send_sample(sample_vec_t smp);
    int gap;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_sample(smp);
  endtask

  // Hold input, wait for every predicted column, then let the pipe settle
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(qsw_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
  endtask

  // Sometimes set junk above the register width
  function automatic logic [CFG_DATA_W-1:0] with_junk(int value, int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom) << width;
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'(value) | junk;
    return CFG_DATA_W'(value);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int mag;
    case ($urandom_range(0, 5))
      0: return SAMPLE_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: mag = 128 * $urandom_range(0, 40);
      default: mag = $urandom_range(0, 1 << $urandom_range(4, 14));
    endcase
    return $urandom_range(0, 1) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
  endfunction

  function automatic sample_vec_t lanes16(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                          logic [15:0] a3, logic [15:0] a4, logic [15:0] a5);
    sample_vec_t v;
    v[0] = a0; v[1] = a1; v[2] = a2; v[3] = a3; v[4] = a4; v[5] = a5;
    return v;
  endfunction

  function automatic column_vec_t lanes8(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                         logic [7:0] a3, logic [7:0] a4, logic [7:0] a5);
    column_vec_t v;
    v[0] = a0; v[1] = a1; v[2] = a2; v[3] = a3; v[4] = a4; v[5] = a5;
    return v;
  endfunction

  function automatic stim_row_t cfg_row(qsw_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.is_cfg   = 1'b1;
    r.idx      = idx;
    r.data     = data;
    r.smp      = '0;
    r.has_exp  = 1'b0;
    r.exp_cols = '0;
    return r;
  endfunction

  function automatic stim_row_t smp_row(sample_vec_t smp, logic has_exp, column_vec_t cols);
    stim_row_t r;
    r.is_cfg   = 1'b0;
    r.idx      = qsw_pkg::CFG_CHANNELS;
    r.data     = '0;
    r.smp      = smp;
    r.has_exp  = has_exp;
    r.exp_cols = cols;
    return r;
  endfunction

  // Compare each accepted column with the oldest prediction
  always @(posedge clk_i) begin : check_columns
    column_t want;
    logic [COL_W-1:0] got;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_columns.size() == 0) begin
        $display("%0t: unexpected column: expected none, actual data %h last %b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = expected_columns.pop_front();
        for (int c = 0; c < NCH; c++) begin
          got = m_axis_tdata_o[c*COL_W +: COL_W];
          if (got !== want.cols[c]) begin
            $display("%0t: column_ch%0d expected %0d actual %0d", $time, c,
                     $signed(want.cols[c]), $signed(got));
            errors++;
          end
        end
        if (m_axis_tdata_o[NCH*COL_W +: TIDX_W] !== want.tidx) begin
          $display("%0t: time_index expected %0d actual %0d", $time, want.tidx,
                   m_axis_tdata_o[NCH*COL_W +: TIDX_W]);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last_column expected %b actual %b", $time, want.last,
                   m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  initial begin : output_ready
    int gap;
    int burst;
    burst = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(burst);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin : watchdog
    #30000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    column_t     col;
    sample_vec_t smp;
    int          phase;
    int          sent;
    int          n_items;
    int          sel;
    int          wl;
    int          hop;
    logic [CFG_DATA_W-1:0] inv;

    reg_channels = qsw_pkg::CHANNELS_RST;
    reg_window   = qsw_pkg::WINDOW_RST;
    reg_hop      = qsw_pkg::HOP_RST;
    reg_inv      = qsw_pkg::INV_SCALE_RST;
    reg_zp       = qsw_pkg::ZERO_PT_RST;
    write_head   = 0;
    fill_count   = 0;
    since_emit   = 0;

    // Window of one: every sample comes straight back as one column
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_WINDOW_LEN, 24'd1));
    stim_rows.push_back(smp_row({6{16'h0100}}, 1'b1, {6{8'h01}}));
    stim_rows.push_back(smp_row({6{16'h7FFF}}, 1'b1, {6{8'h7F}}));
    stim_rows.push_back(smp_row({6{16'h8000}}, 1'b1, {6{8'h80}}));
    // halves round away from zero, tiny negatives round to zero
    stim_rows.push_back(smp_row(lanes16(16'h0080, 16'hFF80, 16'h017F, 16'hFE80, 16'h0000,
                                        16'hFFFF), 1'b1,
                                lanes8(8'h01, 8'hFF, 8'h01, 8'hFE, 8'h00, 8'h00)));
    // zero scale leaves only the zero point
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_INV_SCALE, 24'd0));
    stim_rows.push_back(smp_row(lanes16(16'h1234, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
                                        16'h5555), 1'b1, {6{8'h00}}));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_ZERO_POINT, 24'h80));
    stim_rows.push_back(smp_row({6{16'h7FFF}}, 1'b1, {6{8'h80}}));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_ZERO_POINT, 24'h7F));
    stim_rows.push_back(smp_row({6{16'h8000}}, 1'b1, {6{8'h7F}}));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_INV_SCALE, 24'hFFFFFF));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_ZERO_POINT, 24'h00));
    stim_rows.push_back(smp_row(lanes16(16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0002,
                                        16'hFFFE), 1'b1,
                                lanes8(8'h01, 8'hFF, 8'h7F, 8'h80, 8'h02, 8'hFE)));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_CHANNELS, 24'd1));
    stim_rows.push_back(smp_row({6{16'h0100}}, 1'b1,
                                lanes8(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_CHANNELS, 24'd0));
    stim_rows.push_back(smp_row({6{16'h7FFF}}, 1'b1, {6{8'h00}}));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_CHANNELS, 24'd7));
    stim_rows.push_back(smp_row({6{16'h0100}}, 1'b1, {6{8'h7F}}));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_INV_SCALE, 24'd65536));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_CHANNELS, 24'd6));
    // window length zero acts as one
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_WINDOW_LEN, 24'd0));
    stim_rows.push_back(smp_row(lanes16(16'h0300, 16'hFD00, 16'h0300, 16'hFD00, 16'h0300,
                                        16'hFD00), 1'b1,
                                lanes8(8'h03, 8'hFD, 8'h03, 8'hFD, 8'h03, 8'hFD)));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_WINDOW_LEN, 24'd3));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_HOP_LEN, 24'd1));
    for (int i = 0; i < 4; i++)
      stim_rows.push_back(smp_row(lanes16(16'(16'h0100 * (i + 1)), 16'(16'hF000 + i),
                                          16'(16'h0040 * i), 16'(16'h8000 + i),
                                          16'(16'h7FFF - i), 16'(16'h0555 * i)),
                                  1'b0, '0));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_HOP_LEN, 24'd0));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_CHANNELS, 24'd3));
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_WINDOW_LEN, 24'd3));
    stim_rows.push_back(smp_row({6{16'h0A00}}, 1'b0, '0));
    // restart a partly filled window
    stim_rows.push_back(cfg_row(qsw_pkg::CFG_WINDOW_LEN, 24'd2));
    for (int i = 0; i < 4; i++)
      stim_rows.push_back(smp_row(lanes16(16'(16'h0200 + 16'h80 * i), 16'(16'hFE00 - i),
                                          16'(16'h1000 * i), 16'(16'h0080 * i),
                                          16'h00C0, 16'hFF40),
                                  1'b0, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        write_register(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_sample(stim_rows[i].smp);
        if (stim_rows[i].has_exp) begin
          col = expected_columns.pop_back();
          col.cols = stim_rows[i].exp_cols;
          expected_columns.push_back(col);
        end
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 2) begin
        // longest hop: one window after 255 samples
        write_register(qsw_pkg::CFG_WINDOW_LEN, with_junk(3, qsw_pkg::WL_W));
        write_register(qsw_pkg::CFG_HOP_LEN, 24'd255);
        n_items = 260;
      end else begin
        if (phase == 0 || $urandom_range(0, 4) != 0) begin
          sel = $urandom_range(0, 9);
          if (sel < 6) wl = $urandom_range(1, 8);
          else if (sel < 8) wl = $urandom_range(9, 24);
          else if (sel == 8) wl = WIN_MAX;
          else wl = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
          write_register(qsw_pkg::CFG_WINDOW_LEN, with_junk(wl, qsw_pkg::WL_W));
        end
        sel = $urandom_range(0, 9);
        if (sel < 4) hop = 0;
        else if (sel < 8) hop = $urandom_range(1, eff_window() + 3);
        else hop = $urandom_range(1, 30);
        write_register(qsw_pkg::CFG_HOP_LEN, with_junk(hop, qsw_pkg::HOP_W));
        n_items = eff_window() + $urandom_range(4, 40);
        if (n_items > RANDOM_ITEMS - sent) n_items = RANDOM_ITEMS - sent;
      end
      if ($urandom_range(0, 2) != 0)
        write_register(qsw_pkg::CFG_CHANNELS,
                       with_junk($urandom_range(0, 7), qsw_pkg::CH_CNT_W));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       inv = 24'd0;
          1:       inv = 24'hFFFFFF;
          2:       inv = qsw_pkg::INV_SCALE_RST;
          3:       inv = CFG_DATA_W'($urandom);
          default: inv = CFG_DATA_W'($urandom_range(1024, 196608));
        endcase
        write_register(qsw_pkg::CFG_INV_SCALE, inv);
      end
      if ($urandom_range(0, 2) == 0)
        write_register(qsw_pkg::CFG_ZERO_POINT,
                       with_junk($urandom_range(0, 255), qsw_pkg::ZP_W));
      else if ($urandom_range(0, 2) == 0)
        write_register(qsw_pkg::CFG_ZERO_POINT, 24'd0);

      for (int i = 0; i < n_items; i++) begin
        for (int c = 0; c < NCH; c++) smp[c] = rand_sample();
        send_sample(smp);
      end
      sent += n_items;
      phase++;
    end

    drain_block();
    if (errors == 0 && expected_columns.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
